FILE: hw/rtl/fmtf_pkg.sv
// Package for the truncating single-precision multiplier.
// Holds the float field widths and the fixed result encodings; no dependencies.
package fmtf_pkg;
    localparam int EXP_W  = 8;
    localparam int FRAC_W = 23;
    localparam int SIG_W  = FRAC_W + 1;
    localparam int PROD_W = 2 * SIG_W;
    localparam logic [31:0] NAN_OUT = 32'h7fff_ffff;
    localparam logic [31:0] INF_OUT = 32'h7f80_0000;
    localparam logic [EXP_W-1:0] EXP_ALL_ONES = 8'hff;
    localparam logic [EXP_W-1:0] EXP_MAX_FINITE = 8'hfe;
    localparam logic [FRAC_W-1:0] FRAC_MASK = 23'h7f_ffff;
    localparam logic [9:0] EXP_BIAS = 10'd127;
endpackage

FILE: hw/rtl/float32_multiply_truncating_flush.sv
// Top level of the truncating single-precision multiplier.
// Depends on fmtf_pkg for widths and special encodings.

// One product per cycle while the output is not stalled: operands are
// registered on acceptance, then the 24x24 significand multiply, one-place
// normalize and special-case select feed the result register, which drives
// m_tdata (two register stages), and a new transaction is taken every cycle
// unless a stalled output holds both registers full. NaN gives 0x7fffffff, any zero
// exponent gives +0, infinity gives +inf; no rounding, denormals flushed.
module float32_multiply_truncating_flush
    import fmtf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] operand_a, [63:32] operand_b
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [31:0] product
);
    logic        in_vld_reg;
    logic [31:0] a_reg, b_reg;
    logic        out_vld_reg;
    logic [31:0] out_reg;
    logic        adv_out, adv_in;

    assign adv_out  = !out_vld_reg || m_tready;
    assign adv_in   = !in_vld_reg || adv_out;
    assign s_tready = adv_in;
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_reg;

    // operand register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (adv_in)
            in_vld_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (adv_in && s_tvalid)
        begin
            a_reg <= s_tdata[31:0];
            b_reg <= s_tdata[63:32];
        end
    end

    // multiply and normalize
    logic [EXP_W-1:0]  ea, eb;
    logic [SIG_W-1:0]  fa, fb;
    logic [PROD_W-1:0] prod;
    logic [SIG_W:0]    top;
    logic [SIG_W-1:0]  sig;
    logic [9:0]        e;
    logic              sgn, nan_a, nan_b;
    logic [31:0]       out_next;

    always_comb
    begin
        ea    = a_reg[30:23];
        eb    = b_reg[30:23];
        fa    = {1'b1, a_reg[FRAC_W-1:0]};
        fb    = {1'b1, b_reg[FRAC_W-1:0]};
        sgn   = a_reg[31] ^ b_reg[31];
        prod  = PROD_W'(fa) * PROD_W'(fb);
        top   = prod[PROD_W-1:FRAC_W];
        e     = {2'b00, ea} + {2'b00, eb} - EXP_BIAS;
        sig   = top[SIG_W-1:0];
        if (top[SIG_W])
        begin
            sig = top[SIG_W:1];
            e   = e + 10'd1;
        end
        nan_a = (ea == EXP_ALL_ONES) && (a_reg[FRAC_W-1:0] != '0);
        nan_b = (eb == EXP_ALL_ONES) && (b_reg[FRAC_W-1:0] != '0);
        if (nan_a || nan_b)
            out_next = NAN_OUT;
        else if (ea == '0 || eb == '0)
            out_next = '0;
        else if (ea == EXP_ALL_ONES || eb == EXP_ALL_ONES)
            out_next = INF_OUT;
        else if (e[9] || e == '0)
            out_next = {sgn, 31'd0};
        else if (e >= 10'd255)
            out_next = {sgn, EXP_MAX_FINITE, FRAC_MASK};
        else
            out_next = {sgn, e[7:0], sig[FRAC_W-1:0]};
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (adv_out)
            out_vld_reg <= in_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv_out && in_vld_reg)
            out_reg <= out_next;
    end

`ifndef SYNTHESIS
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");
    a_pass: assert property (@(posedge clk) disable iff (!rst_n)
        in_vld_reg && adv_out |=> out_vld_reg)
        else $error("operand lost");
    a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
        !out_vld_reg |-> s_tready)
        else $error("stalled with empty output");
`endif
endmodule

FILE: verif/float32_multiply_truncating_flush_test.sv
// Testbench for the truncating single-precision multiplier.
// Self-checking against an internal product predictor; depends on fmtf_pkg and the RTL top.
module float32_multiply_truncating_flush_test
    import fmtf_pkg::*;
;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;   // [31:0] operand_a, [63:32] operand_b
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // [31:0] product

    logic [31:0] expected_products[$];
    int          mismatch_count;
    int          idle_cycles;
    bit          hold_off_req;
    bit          rx_random_stall;

    float32_multiply_truncating_flush u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    // Predicted truncated product of two single-precision patterns
    function automatic logic [31:0] truncated_product(logic [31:0] a, logic [31:0] b);
        logic              sign;
        logic [EXP_W-1:0]  ea;
        logic [EXP_W-1:0]  eb;
        logic [SIG_W-1:0]  sa;
        logic [SIG_W-1:0]  sb;
        logic [PROD_W-1:0] full;
        logic [PROD_W-1:0] kept;
        int                e;
        logic [FRAC_W-1:0] frac;
        sign = a[31] ^ b[31];
        ea = a[30:23];
        eb = b[30:23];
        sa = {1'b1, a[22:0]};
        sb = {1'b1, b[22:0]};
        if ((ea == EXP_ALL_ONES && a[22:0] != 0) || (eb == EXP_ALL_ONES && b[22:0] != 0))
            return NAN_OUT;
        if (ea == 0 || eb == 0)
            return 32'h0;
        if (ea == EXP_ALL_ONES || eb == EXP_ALL_ONES)
            return INF_OUT;
        e = int'(ea) + int'(eb) - int'(EXP_BIAS);
        full = PROD_W'(sa) * PROD_W'(sb);
        kept = full >> FRAC_W;
        // one-place normalize when the product reaches 2.0
        if (kept[SIG_W])
        begin
            kept = kept >> 1;
            e++;
        end
        frac = kept[FRAC_W-1:0];
        if (e <= 0)
            return {sign, 31'h0};
        if (e >= 255)
            return {sign, EXP_MAX_FINITE, FRAC_MASK};
        return {sign, e[7:0], frac};
    endfunction

    // Send one operand pair, waiting a random gap first unless no_gap is set
    task automatic send_pair(logic [31:0] a, logic [31:0] b, bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b, a};
        expected_products.push_back(truncated_product(a, b));
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic end_burst();
        s_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    // Random operand biased toward interesting exponents and zero fractions
    function automatic logic [31:0] random_operand();
        logic [31:0] v;
        v = $urandom();
        case ($urandom_range(0, 9))
            0: v[30:23] = 8'h00;
            1: v[30:23] = 8'hff;
            2: v[30:23] = 8'($urandom_range(0, 8));
            3: v[30:23] = 8'($urandom_range(240, 254));
            4: v[22:0]  = 23'h0;
            default: v[30:23] = 8'($urandom_range(100, 154));
        endcase
        return v;
    endfunction

    task automatic test_special_operands();
        send_pair(32'h7fc0_0000, 32'h3f80_0000);
        send_pair(32'h3f80_0000, 32'hff80_0001);
        send_pair(32'h7f80_0001, 32'h0000_0000);
        send_pair(32'h7f80_0000, 32'h0000_0000);
        send_pair(32'h0000_0001, 32'h3f80_0000);
        send_pair(32'h8000_0000, 32'hbf80_0000);
        send_pair(32'hff80_0000, 32'h3f80_0000);
        send_pair(32'hff80_0000, 32'hff80_0000);
        send_pair(32'hffff_ffff, 32'hffff_ffff);
        end_burst();
    endtask

    task automatic test_normal_range();
        send_pair(32'h3f80_0000, 32'h3f80_0000);
        send_pair(32'h3fff_ffff, 32'h3fff_ffff);
        send_pair(32'hbfc0_0000, 32'h4000_0000);
        send_pair(32'h7f7f_ffff, 32'h7f7f_ffff);
        send_pair(32'hff7f_ffff, 32'h7f7f_ffff);
        send_pair(32'h0080_0000, 32'h0080_0000);
        send_pair(32'h8080_0000, 32'h3f00_0000);
        send_pair(32'h0080_0000, 32'h3f80_0000);
        send_pair(32'h3f80_0001, 32'h3f7f_ffff);
        send_pair(32'h5555_5555, 32'haaaa_aaaa);
        end_burst();
    endtask

    task automatic test_random_stream(int count);
        repeat (count)
            send_pair(random_operand(), random_operand());
        end_burst();
    endtask

    // Receiver holds off while the sender streams back to back
    task automatic test_back_pressure();
        hold_off_req = 1'b1;
        repeat (40)
            send_pair(random_operand(), random_operand(), 1'b1);
        end_burst();
    endtask

    // Receiver: random stalls, plus one long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= !rx_random_stall;
        end
    end

    initial
    begin
        int stall;
        rx_random_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                rx_random_stall = 1'b1;
                repeat (60) @(posedge clk);
                rx_random_stall = 1'b0;
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                // stretches with no stalls between bursts of stalls
                stall = $urandom_range(0, 3);
                rx_random_stall = (stall != 0);
                repeat (stall) @(posedge clk);
                rx_random_stall = 1'b0;
            end
        end
    end

    // Check each product transaction against the oldest prediction
    always @(posedge clk)
    begin
        logic [31:0] want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_products.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected product %h", m_tdata);
            end
            else
            begin
                want = expected_products.pop_front();
                if (m_tdata !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("product mismatch: expected %h actual %h", want, m_tdata);
                end
            end
        end
    end

    // Watchdog on cycles with no transaction on either side
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("float32_multiply_truncating_flush_test: errors");
            $finish;
        end
    end

    initial
    begin
        mismatch_count = 0;
        idle_cycles    = 0;
        hold_off_req   = 1'b0;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 64'h0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_special_operands();
        test_normal_range();
        test_back_pressure();
        test_random_stream(1240);
        while (expected_products.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_products.size() == 0)
            $display("float32_multiply_truncating_flush_test: clean");
        else
            $display("float32_multiply_truncating_flush_test: errors");
        $finish;
    end
endmodule
